FILE: sv/dmpe_pkg.sv
package dmpe_pkg;

    typedef enum logic [2:0] {
        PH_FIXED = 3'd0,
        PH_HSKIP = 3'd1,
        PH_HLEN  = 3'd2,
        PH_HCOPY = 3'd3,
        PH_HPAD  = 3'd4,
        PH_BLEN  = 3'd5,
        PH_BCOPY = 3'd6
    } phase_t;

    localparam logic [31:0] FIXED_HDR_LEN  = 32'd16;
    localparam logic [31:0] FIXED_HDR_LAST = 32'd15;
    localparam logic [31:0] EMPTY_BODY_LEN = 32'd4;
    localparam logic [2:0]  PREFIX_LAST    = 3'd3;

    typedef struct packed {
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       in_body;
        logic       param_end;
        logic       msg_end;
    } result_t;

    // Room left in the result queue, as seen by the parser.
    typedef struct packed {
        logic room1;
        logic room2;
    } queue_status_t;

endpackage

FILE: sv/dmpe_stream_if.sv
interface dmpe_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

FILE: sv/dmpe_parser.sv
module dmpe_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    dmpe_stream_if.sink            in_ch,
    input  dmpe_pkg::queue_status_t status,
    output logic                   push_valid,
    output dmpe_pkg::result_t      push_data
);

    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;

    logic [31:0]         position_reg, position_next;
    logic [31:0]         header_end_reg, header_end_next;
    logic [31:0]         body_size_reg, body_size_next;
    dmpe_pkg::phase_t    phase_reg, phase_next;
    logic [2:0]          prefix_reg, prefix_next;
    logic [31:0]         length_reg, length_next;
    logic [31:0]         copy_reg, copy_next;
    logic [2:0]          align_reg, align_next;

    logic                accept;
    logic [31:0]         pos_inc;
    logic [31:0]         len_with_byte;
    logic [31:0]         len_plus_one;
    logic [31:0]         copy_dec;
    logic [31:0]         msg_len;
    logic                last;
    logic                r_valid;
    logic                r_body;
    logic                r_pend;

    assign in_ch.ready = s1_valid_reg ? status.room2 : status.room1;
    assign accept      = in_ch.valid && in_ch.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= in_ch.data.in_byte;
        end
    end

    assign pos_inc       = position_reg + 32'd1;
    assign len_with_byte = length_reg | (32'(s1_byte_reg) << {prefix_reg[1:0], 3'b000});
    assign len_plus_one  = len_with_byte + 32'd1;
    assign copy_dec      = copy_reg - 32'd1;

    always_comb
    begin
        position_next   = position_reg;
        header_end_next = header_end_reg;
        body_size_next  = body_size_reg;
        phase_next      = phase_reg;
        prefix_next     = prefix_reg;
        length_next     = length_reg;
        copy_next       = copy_reg;
        align_next      = align_reg;
        r_valid         = 1'b0;
        r_body          = 1'b0;
        r_pend          = 1'b0;

        case (phase_reg)
            dmpe_pkg::PH_FIXED:
            begin
                if (position_reg[31:2] == 30'd1)
                begin
                    body_size_next = body_size_reg
                                   | (32'(s1_byte_reg) << {position_reg[1:0], 3'b000});
                end
                if (position_reg[31:2] == 30'd3)
                begin
                    length_next = length_reg
                                | (32'(s1_byte_reg) << {position_reg[1:0], 3'b000});
                end
                if (position_reg >= dmpe_pkg::FIXED_HDR_LAST)
                begin
                    header_end_next = length_next + dmpe_pkg::FIXED_HDR_LEN;
                    if (body_size_next == dmpe_pkg::EMPTY_BODY_LEN)
                    begin
                        body_size_next = '0;
                    end
                    prefix_next = '0;
                    length_next = '0;
                    phase_next  = (dmpe_pkg::FIXED_HDR_LEN < header_end_next)
                                ? dmpe_pkg::PH_HSKIP : dmpe_pkg::PH_BLEN;
                end
            end
            dmpe_pkg::PH_HSKIP:
            begin
                prefix_next = prefix_reg + 3'd1;
                if (prefix_reg >= dmpe_pkg::PREFIX_LAST)
                begin
                    prefix_next = '0;
                    length_next = '0;
                    phase_next  = dmpe_pkg::PH_HLEN;
                end
            end
            dmpe_pkg::PH_HLEN:
            begin
                length_next = len_with_byte;
                prefix_next = prefix_reg + 3'd1;
                if (prefix_reg >= dmpe_pkg::PREFIX_LAST)
                begin
                    prefix_next = '0;
                    copy_next   = len_plus_one;
                    align_next  = 3'd0 - len_plus_one[2:0];
                    if (len_plus_one == '0)
                    begin
                        length_next = '0;
                        phase_next  = (pos_inc < header_end_reg)
                                    ? dmpe_pkg::PH_HSKIP : dmpe_pkg::PH_BLEN;
                    end
                    else
                    begin
                        phase_next = dmpe_pkg::PH_HCOPY;
                    end
                end
            end
            dmpe_pkg::PH_HCOPY:
            begin
                r_valid   = 1'b1;
                copy_next = copy_dec;
                if (copy_dec == '0)
                begin
                    r_pend = 1'b1;
                    if (align_reg != '0)
                    begin
                        phase_next = dmpe_pkg::PH_HPAD;
                    end
                    else
                    begin
                        prefix_next = '0;
                        length_next = '0;
                        phase_next  = (pos_inc < header_end_reg)
                                    ? dmpe_pkg::PH_HSKIP : dmpe_pkg::PH_BLEN;
                    end
                end
            end
            dmpe_pkg::PH_HPAD:
            begin
                align_next = align_reg - 3'd1;
                if (align_next == '0)
                begin
                    prefix_next = '0;
                    length_next = '0;
                    phase_next  = (pos_inc < header_end_reg)
                                ? dmpe_pkg::PH_HSKIP : dmpe_pkg::PH_BLEN;
                end
            end
            dmpe_pkg::PH_BLEN:
            begin
                length_next = len_with_byte;
                prefix_next = prefix_reg + 3'd1;
                if (prefix_reg >= dmpe_pkg::PREFIX_LAST)
                begin
                    prefix_next = '0;
                    copy_next   = len_plus_one;
                    length_next = '0;
                    if (len_plus_one != '0)
                    begin
                        phase_next = dmpe_pkg::PH_BCOPY;
                    end
                end
            end
            dmpe_pkg::PH_BCOPY:
            begin
                r_valid   = 1'b1;
                r_body    = 1'b1;
                copy_next = copy_dec;
                if (copy_dec == '0)
                begin
                    r_pend      = 1'b1;
                    length_next = '0;
                    prefix_next = '0;
                    phase_next  = dmpe_pkg::PH_BLEN;
                end
            end
            default:
            begin
                phase_next = dmpe_pkg::PH_FIXED;
            end
        endcase

        // message end uses the sizes as they stand after this byte
        msg_len = header_end_next + body_size_next;
        last    = (position_reg >= dmpe_pkg::FIXED_HDR_LAST) && (pos_inc >= msg_len);

        if (last)
        begin
            r_pend          = r_pend | r_valid;
            position_next   = '0;
            header_end_next = '0;
            body_size_next  = '0;
            phase_next      = dmpe_pkg::PH_FIXED;
            prefix_next     = '0;
            length_next     = '0;
            copy_next       = '0;
            align_next      = '0;
        end
        else
        begin
            position_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            header_end_reg <= '0;
            body_size_reg  <= '0;
            phase_reg      <= dmpe_pkg::PH_FIXED;
            prefix_reg     <= '0;
            length_reg     <= '0;
            copy_reg       <= '0;
            align_reg      <= '0;
        end
        else if (s1_valid_reg)
        begin
            position_reg   <= position_next;
            header_end_reg <= header_end_next;
            body_size_reg  <= body_size_next;
            phase_reg      <= phase_next;
            prefix_reg     <= prefix_next;
            length_reg     <= length_next;
            copy_reg       <= copy_next;
            align_reg      <= align_next;
        end
    end

    assign push_valid          = s1_valid_reg;
    assign push_data.out_valid = r_valid;
    assign push_data.out_byte  = r_valid ? s1_byte_reg : 8'd0;
    assign push_data.in_body   = r_body;
    assign push_data.param_end = r_pend;
    assign push_data.msg_end   = last;

endmodule

FILE: sv/dmpe_result_fifo.sv
module dmpe_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    input  dmpe_pkg::result_t       push_data,
    output dmpe_pkg::queue_status_t status,
    dmpe_stream_if.source           out_ch
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dmpe_pkg::result_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign pop = out_ch.valid && out_ch.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign status.room1 = count_reg < CNT_W'(DEPTH);
    assign status.room2 = count_reg < CNT_W'(DEPTH - 1);
    assign out_ch.valid = count_reg != '0;
    assign out_ch.data  = entry_reg[rd_ptr_reg];

endmodule

FILE: sv/dbus_message_param_extractor_unit.sv
// D-Bus message parameter extractor.
// in_ch carries the message one byte per beat; out_ch gives exactly one result
// beat per input beat, in order: a copied string byte (out_valid), whether it
// belongs to a body parameter (in_body), and the parameter-end and
// message-end marks. After the last byte of a message the next byte starts a
// new message.
// A byte taken from in_ch is registered in the input register, parsed from
// there and written into the result queue, from which its result is offered.
// Throughput: one byte per cycle while the result queue has room. The parser
// keeps all its counters in registers updated once per byte.
// Reset puts the parser in the fixed-header phase with all counters clear and
// empties the result queue.
// When the receiver stalls, results pile up in the DEPTH-entry result queue;
// in_ch.ready drops once the queue and the parse stage together would fill it
// and rises again as soon as results are taken. DEPTH must be at least 3 to
// keep one byte per cycle.
module dbus_message_param_extractor_unit #(
    parameter int DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    dmpe_stream_if.sink   in_ch,
    dmpe_stream_if.source out_ch
);

    logic                    push_valid;
    dmpe_pkg::result_t       push_data;
    dmpe_pkg::queue_status_t status;

    dmpe_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .status     (status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    dmpe_result_fifo #(
        .DEPTH (DEPTH)
    ) u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .status     (status),
        .out_ch     (out_ch)
    );

    // credit scheme must leave a free slot for every parsed byte
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> status.room1)
    else $error("result queue overrun");

    // an accepted byte is parsed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> push_valid)
    else $error("accepted beat not parsed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.param_end) |-> out_ch.data.out_valid)
    else $error("parameter end without a copied byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.data.out_valid)
            |-> (out_ch.data.out_byte == 8'd0 && !out_ch.data.in_body))
    else $error("payload on an empty result beat");

endmodule
